// ===== rtl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// types, codes and constants shared by the handle table modules
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam logic [15:0] GEN_RESET = 16'd1;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_RESOLVE  = 2'd1,
    OP_DESTROY  = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_LOOK,
    ST_CHECK,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] object_key;
    logic [7:0]  stage_tag;
    logic [31:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [31:0] handle_out;
    logic [31:0] resolved_key;
    logic        success;
    logic [6:0]  live_entries;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  stage;
    logic [15:0] gen;
  } slot_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic scan;
    logic look;
    logic check;
    logic write_new;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       key_zero;
    logic       handle_bad;
    logic       hit;
    logic       scan_last;
    logic       empty_avail;
    logic       clr_last;
  } dp_stat_t;

endpackage

// ===== rtl/generational_handle_table.sv =====
// register with a nonzero key scans the slots from accept to response, one slot compared
// per cycle on the single ram port; a duplicate ends the scan early. resolve and
// destroy read the addressed slot once, while bad handles, null keys and nop answer
// without a ram access. one request at a time, the next accepted the cycle after the
// response is loaded. after reset the block sweeps the ram, clearing every slot and
// stalling requests.
// ----------------------------------------------------------------------------
// generational_handle_table
// slot map of object keys with generation-checked handles
// ----------------------------------------------------------------------------
module generational_handle_table
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ght_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ght_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .out_rsp_o (out_rsp_o),
    .cmd_i     (cmd),
    .stat_o    (stat)
  );

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.success |->
      out_rsp_o.handle_out == '0 && out_rsp_o.resolved_key == '0)
    else $error("failed request returned nonzero data");

  a_handle_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.handle_out != '0 |->
      out_rsp_o.handle_out[15:0] != '0 && out_rsp_o.handle_out[31:16] != '0
      && out_rsp_o.resolved_key == '0 && out_rsp_o.success)
    else $error("malformed handle");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr, cmd.accept, cmd.scan, cmd.look, cmd.check,
              cmd.write_new, cmd.load_out}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== rtl/ght_ram.sv =====
// ----------------------------------------------------------------------------
// ght_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ght_ctrl.sv =====
// ----------------------------------------------------------------------------
// ght_ctrl
// sequencer for clear, register scan, resolve and destroy
// ----------------------------------------------------------------------------
module ght_ctrl
  import ght_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat_i.op)
          OP_REGISTER: state_d = stat_i.key_zero ? ST_FINISH : ST_SCAN;
          OP_RESOLVE, OP_DESTROY: state_d = stat_i.handle_bad ? ST_FINISH : ST_LOOK;
          default: state_d = ST_FINISH;
        endcase
      end
      ST_LOOK:  state_d = ST_CHECK;
      ST_CHECK: state_d = ST_FINISH;
      ST_SCAN: begin
        if (stat_i.hit) begin
          state_d = ST_FINISH;
        end else if (stat_i.scan_last) begin
          state_d = stat_i.empty_avail ? ST_WRITE : ST_FINISH;
        end
      end
      ST_WRITE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_LOOK:   cmd_o.look = 1'b1;
      ST_CHECK:  cmd_o.check = 1'b1;
      ST_SCAN:   cmd_o.scan = 1'b1;
      ST_WRITE:  cmd_o.write_new = 1'b1;
      ST_FINISH: cmd_o.load_out = out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/ght_dp.sv =====
// ----------------------------------------------------------------------------
// ght_dp
// slot storage, scan and check logic, live count and response register
// ----------------------------------------------------------------------------
module ght_dp
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  req_t      in_req_i,
  output rsp_t      out_rsp_o,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o
);

  localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(SLOT_COUNT - 1);

  req_t req_q;
  rsp_t rsp_q;

  logic [ADDR_W-1:0] issue_idx_q, issue_idx_d;
  logic              issue_done_q, issue_done_d;
  logic              rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0] rd_idx_q, rd_idx_d;
  logic              empty_q, empty_d;
  logic [ADDR_W-1:0] empty_idx_q, empty_idx_d;
  logic [15:0]       empty_gen_q, empty_gen_d;
  logic [31:0]       res_handle_q, res_handle_d;
  logic [31:0]       res_key_q, res_key_d;
  logic              res_ok_q, res_ok_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  slot_t             ram_wdata;
  slot_t             rd;

  logic [15:0]       h_enc;
  logic [15:0]       h_gen;
  logic [ADDR_W-1:0] h_slot;
  logic              chk_ok;
  logic              hit_now;
  logic              emp_now;
  logic [15:0]       next_gen;

  assign h_enc   = req_q.handle_in[15:0];
  assign h_gen   = req_q.handle_in[31:16];
  assign h_slot  = ADDR_W'(h_enc - 16'd1);
  assign chk_ok  = (rd.key != '0) && (rd.gen == h_gen) && (rd.stage == req_q.stage_tag);
  assign hit_now = (rd.key == req_q.object_key) && (rd.stage == req_q.stage_tag);
  assign emp_now = (rd.key == '0);
  assign next_gen = ((rd.gen + 16'd1) == 16'd0) ? GEN_RESET : rd.gen + 16'd1;

  ght_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rd)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = issue_idx_q;
    ram_wdata = '{key: '0, stage: '0, gen: GEN_RESET};
    if (cmd_i.clr) begin
      ram_we = 1'b1;
    end else if (cmd_i.look) begin
      ram_addr = h_slot;
    end else if (cmd_i.check) begin
      ram_addr  = h_slot;
      ram_we    = (req_q.opcode == OP_DESTROY) && chk_ok;
      ram_wdata = '{key: '0, stage: '0, gen: next_gen};
    end else if (cmd_i.write_new) begin
      ram_addr  = empty_idx_q;
      ram_we    = 1'b1;
      ram_wdata = '{key: req_q.object_key, stage: req_q.stage_tag, gen: empty_gen_q};
    end
  end

  always_comb begin
    issue_idx_d  = issue_idx_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = cmd_i.scan && !issue_done_q;
    rd_idx_d     = issue_idx_q;
    empty_d      = empty_q;
    empty_idx_d  = empty_idx_q;
    empty_gen_d  = empty_gen_q;
    res_handle_d = res_handle_q;
    res_key_d    = res_key_q;
    res_ok_d     = res_ok_q;
    count_d      = count_q;

    if (cmd_i.clr) begin
      issue_idx_d = (issue_idx_q == LAST_IDX) ? '0 : issue_idx_q + 1'b1;
    end

    if (cmd_i.accept) begin
      issue_idx_d  = '0;
      issue_done_d = 1'b0;
      empty_d      = 1'b0;
      res_handle_d = '0;
      res_key_d    = '0;
      res_ok_d     = 1'b0;
    end

    if (cmd_i.scan) begin
      if (!issue_done_q) begin
        if (issue_idx_q == LAST_IDX) begin
          issue_done_d = 1'b1;
        end else begin
          issue_idx_d = issue_idx_q + 1'b1;
        end
      end
      if (rd_vld_q) begin
        if (hit_now) begin
          res_handle_d = {rd.gen, 16'(rd_idx_q) + 16'd1};
          res_ok_d     = 1'b1;
        end
        if (emp_now && !empty_q) begin
          empty_d     = 1'b1;
          empty_idx_d = rd_idx_q;
          empty_gen_d = rd.gen;
        end
      end
    end

    if (cmd_i.write_new) begin
      res_handle_d = {empty_gen_q, 16'(empty_idx_q) + 16'd1};
      res_ok_d     = 1'b1;
      count_d      = count_q + 1'b1;
    end

    if (cmd_i.check) begin
      if (req_q.opcode == OP_RESOLVE) begin
        res_key_d = chk_ok ? rd.key : '0;
        res_ok_d  = chk_ok;
      end else if (chk_ok) begin
        res_ok_d = 1'b1;
        if (count_q != '0) count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_idx_q  <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      empty_q      <= 1'b0;
      count_q      <= '0;
    end else begin
      issue_idx_q  <= issue_idx_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      empty_q      <= empty_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= in_req_i;
    if (cmd_i.load_out) begin
      rsp_q <= '{handle_out: res_handle_q, resolved_key: res_key_q,
                 success: res_ok_q, live_entries: 7'(count_q)};
    end
    rd_idx_q     <= rd_idx_d;
    empty_idx_q  <= empty_idx_d;
    empty_gen_q  <= empty_gen_d;
    res_handle_q <= res_handle_d;
    res_key_q    <= res_key_d;
    res_ok_q     <= res_ok_d;
  end

  assign out_rsp_o = rsp_q;

  always_comb begin
    stat_o.op          = req_q.opcode;
    stat_o.key_zero    = (req_q.object_key == '0);
    stat_o.handle_bad  = (h_enc == 16'd0) || ({1'b0, h_enc} > 17'(SLOT_COUNT))
                         || (h_gen == 16'd0);
    stat_o.hit         = rd_vld_q && hit_now;
    stat_o.scan_last   = rd_vld_q && (rd_idx_q == LAST_IDX);
    stat_o.empty_avail = empty_q || (rd_vld_q && emp_now);
    stat_o.clr_last    = (issue_idx_q == LAST_IDX);
  end

endmodule
